>>> src/bpc_pkg.sv
// Shared types and constants for the barometric pressure compensation block.
package bpc_pkg;

  // Width of the 32-bit compensation arithmetic and of both dividers.
  localparam int unsigned CALC_W = 32;

  // Value given on both outputs when a request cannot be compensated.
  localparam logic [31:0] ERR_VALUE = 32'hFFFF_D8F1;

  // Fixed constants of the compensation formula.
  localparam logic [31:0] B6_OFFSET   = 32'd4000;
  localparam logic [31:0] B4_OFFSET   = 32'd32768;
  localparam logic [31:0] B7_SCALE    = 32'd50000;
  localparam logic [31:0] P_SQ_COEF   = 32'd3038;
  localparam logic [31:0] P_LIN_COEF  = 32'd7357;
  localparam logic [31:0] P_OFFSET    = 32'd3791;

  // Configuration register indexes.
  typedef enum logic [2:0] {
    REG_AC1_AC2 = 3'd0,
    REG_AC3_AC4 = 3'd1,
    REG_AC5_AC6 = 3'd2,
    REG_B1_B2   = 3'd3,
    REG_MC_MD   = 3'd4,
    REG_OSS     = 3'd5
  } reg_idx_t;

  // Input request payload.
  typedef struct packed {
    logic [15:0] raw_temperature;
    logic [23:0] raw_pressure;
    logic        sample_valid;
  } in_req_t;

  // Result payload.
  typedef struct packed {
    logic signed [15:0] temperature;
    logic signed [31:0] pressure;
    logic               error_flag;
  } out_res_t;

  // Calibration coefficients, already extended to 32 bits.
  typedef struct packed {
    logic [31:0] ac1;
    logic [31:0] ac2;
    logic [31:0] ac3;
    logic [31:0] ac4;
    logic [31:0] ac5;
    logic [31:0] ac6;
    logic [31:0] b1;
    logic [31:0] b2;
    logic [31:0] mc;
    logic [31:0] md;
    logic [1:0]  oss;
  } cal_t;

endpackage

>>> src/bpc_cfg.sv
// Calibration register file with coefficient unpacking and extension.
module bpc_cfg (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             cfg_we,
  input  logic [2:0]       cfg_index,
  input  logic [31:0]      cfg_data,
  output bpc_pkg::cal_t    cal
);

  logic [31:0] ac12_r, ac34_r, ac56_r, b12_r, mcmd_r;
  logic [1:0]  oss_r;

  // Register writes; unknown indexes are ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ac12_r <= '0;
      ac34_r <= '0;
      ac56_r <= '0;
      b12_r  <= '0;
      mcmd_r <= '0;
      oss_r  <= 2'd3;
    end else if (cfg_we) begin
      case (cfg_index)
        bpc_pkg::REG_AC1_AC2: ac12_r <= cfg_data;
        bpc_pkg::REG_AC3_AC4: ac34_r <= cfg_data;
        bpc_pkg::REG_AC5_AC6: ac56_r <= cfg_data;
        bpc_pkg::REG_B1_B2:   b12_r  <= cfg_data;
        bpc_pkg::REG_MC_MD:   mcmd_r <= cfg_data;
        bpc_pkg::REG_OSS:     oss_r  <= cfg_data[1:0];
        default: ;
      endcase
    end
  end

  // Split the packed halves; signed ones are sign-extended, unsigned ones zero-extended.
  always_comb begin
    cal.ac1 = {{16{ac12_r[31]}}, ac12_r[31:16]};
    cal.ac2 = {{16{ac12_r[15]}}, ac12_r[15:0]};
    cal.ac3 = {{16{ac34_r[31]}}, ac34_r[31:16]};
    cal.ac4 = {16'd0, ac34_r[15:0]};
    cal.ac5 = {16'd0, ac56_r[31:16]};
    cal.ac6 = {16'd0, ac56_r[15:0]};
    cal.b1  = {{16{b12_r[31]}}, b12_r[31:16]};
    cal.b2  = {{16{b12_r[15]}}, b12_r[15:0]};
    cal.mc  = {{16{mcmd_r[31]}}, mcmd_r[31:16]};
    cal.md  = {{16{mcmd_r[15]}}, mcmd_r[15:0]};
    cal.oss = oss_r;
  end

endmodule

>>> src/bpc_div.sv
// Pipelined unsigned restoring divider, one quotient bit per stage.
module bpc_div #(
  parameter int unsigned W  = bpc_pkg::CALC_W,
  parameter int unsigned SW = 1
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_vld,
  input  logic [W-1:0]  in_dvd,
  input  logic [W-1:0]  in_dvs,
  input  logic [SW-1:0] in_side,
  output logic          out_vld,
  output logic [W-1:0]  out_quo,
  output logic [SW-1:0] out_side
);

  logic [W-1:0]  rem_r  [W];
  logic [W-1:0]  aq_r   [W];
  logic [W-1:0]  dvs_r  [W];
  logic [SW-1:0] side_r [W];
  logic [W-1:0]  vld_r;

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W-1:0]  rem_p, aq_p, dvs_p;
    logic [SW-1:0] side_p;
    logic          vld_p;
    logic [W:0]    trial, diff;

    // Stage inputs come from the ports or from the previous stage.
    if (k == 0) begin : g_first
      assign rem_p  = '0;
      assign aq_p   = in_dvd;
      assign dvs_p  = in_dvs;
      assign side_p = in_side;
      assign vld_p  = in_vld;
    end else begin : g_next
      assign rem_p  = rem_r[k-1];
      assign aq_p   = aq_r[k-1];
      assign dvs_p  = dvs_r[k-1];
      assign side_p = side_r[k-1];
      assign vld_p  = vld_r[k-1];
    end

    // Shift in the next dividend bit and try to subtract the divisor.
    assign trial = {rem_p, aq_p[W-1]};
    assign diff  = trial - {1'b0, dvs_p};

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_p;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k]  <= diff[W] ? trial[W-1:0] : diff[W-1:0];
        aq_r[k]   <= {aq_p[W-2:0], ~diff[W]};
        dvs_r[k]  <= dvs_p;
        side_r[k] <= side_p;
      end
    end
  end

  assign out_vld  = vld_r[W-1];
  assign out_quo  = aq_r[W-1];
  assign out_side = side_r[W-1];

endmodule

>>> src/barometric_pressure_compensation.sv
// Top level: pressure and temperature compensation pipeline with two dividers.
// One request is accepted per cycle while the output is not stalled; the two 32-stage
// divider pipelines set the depth. A stalled output freezes the whole pipeline, so
// nothing is lost or repeated.
// Reset is synchronous, active low: all valid bits clear, calibration returns
// to zero and oversampling to 3.
module barometric_pressure_compensation (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  bpc_pkg::in_req_t  in_data,
  output logic              out_valid,
  input  logic              out_stall,
  output bpc_pkg::out_res_t out_data,
  input  logic              cfg_we,
  input  logic [2:0]        cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int unsigned W    = bpc_pkg::CALC_W;
  localparam int unsigned SW1  = 32 + 1 + 1 + 24;
  localparam int unsigned SW2  = 16 + 1 + 1;

  bpc_pkg::cal_t cal;
  logic          en;

  bpc_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cal       (cal)
  );

  // The pipeline advances unless a finished result is held by the receiver.
  logic out_vld_r;
  assign en       = !(out_vld_r && out_stall);
  assign in_stall = !en;

  // Stage 1: X1 of the temperature path and the shifted raw pressure.
  logic        s1_vld_r, s1_err_r;
  logic [31:0] s1_x1_r;
  logic [23:0] s1_up_r;
  logic [31:0] ut_m, x1_prod;
  logic [23:0] up_c;

  assign ut_m    = {16'd0, in_data.raw_temperature} - cal.ac6;
  assign x1_prod = ut_m * cal.ac5;
  assign up_c    = in_data.raw_pressure >> (4'd8 - {2'b00, cal.oss});

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (en) begin
      s1_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_err_r <= !in_data.sample_valid;
      s1_x1_r  <= 32'($signed(x1_prod) >>> 15);
      s1_up_r  <= up_c;
    end
  end

  // Temperature divisor and signed-to-magnitude conversion for the first divider.
  logic [31:0] den, dvd1, abs_dvd1, abs_den;
  logic        neg1, err1;
  logic [SW1-1:0] side1_in, side1_out;
  logic        d1_vld;
  logic [31:0] d1_quo;

  assign den      = s1_x1_r + cal.md;
  assign dvd1     = cal.mc << 11;
  assign abs_dvd1 = dvd1[31] ? 32'd0 - dvd1 : dvd1;
  assign abs_den  = den[31] ? 32'd0 - den : den;
  assign neg1     = dvd1[31] ^ den[31];
  assign err1     = s1_err_r || (den == 32'd0);
  assign side1_in = {s1_x1_r, neg1, err1, s1_up_r};

  bpc_div #(.W(W), .SW(SW1)) u_div_t (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s1_vld_r),
    .in_dvd   (abs_dvd1),
    .in_dvs   (abs_den),
    .in_side  (side1_in),
    .out_vld  (d1_vld),
    .out_quo  (d1_quo),
    .out_side (side1_out)
  );

  // Stage 3: B5, temperature and B6.
  logic [31:0] d1_x1, x2t, b5;
  logic        d1_neg, d1_err;
  logic [23:0] d1_up;
  logic [31:0] t_full;
  logic        s3_vld_r, s3_err_r;
  logic [15:0] s3_t_r;
  logic [31:0] s3_b6_r;
  logic [23:0] s3_up_r;

  assign {d1_x1, d1_neg, d1_err, d1_up} = side1_out;
  assign x2t    = d1_neg ? 32'd0 - d1_quo : d1_quo;
  assign b5     = d1_x1 + x2t;
  assign t_full = 32'($signed(b5 + 32'd8) >>> 4);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_vld_r <= 1'b0;
    end else if (en) begin
      s3_vld_r <= d1_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_err_r <= d1_err;
      s3_t_r   <= t_full[15:0];
      s3_b6_r  <= b5 - bpc_pkg::B6_OFFSET;
      s3_up_r  <= d1_up;
    end
  end

  // Stage 4: the three products of B6.
  logic [31:0] sq_prod, ac2_prod, ac3_prod;
  logic        s4_vld_r, s4_err_r;
  logic [15:0] s4_t_r;
  logic [23:0] s4_up_r;
  logic [31:0] s4_sq_r, s4_x2a_r, s4_x1c_r;

  assign sq_prod  = s3_b6_r * s3_b6_r;
  assign ac2_prod = cal.ac2 * s3_b6_r;
  assign ac3_prod = cal.ac3 * s3_b6_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_vld_r <= 1'b0;
    end else if (en) begin
      s4_vld_r <= s3_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_err_r <= s3_err_r;
      s4_t_r   <= s3_t_r;
      s4_up_r  <= s3_up_r;
      s4_sq_r  <= 32'($signed(sq_prod) >>> 12);
      s4_x2a_r <= 32'($signed(ac2_prod) >>> 11);
      s4_x1c_r <= 32'($signed(ac3_prod) >>> 13);
    end
  end

  // Stage 5: products of the squared term.
  logic [31:0] b2_prod, b1_prod;
  logic        s5_vld_r, s5_err_r;
  logic [15:0] s5_t_r;
  logic [23:0] s5_up_r;
  logic [31:0] s5_x1_r, s5_x2b_r, s5_x2a_r, s5_x1c_r;

  assign b2_prod = cal.b2 * s4_sq_r;
  assign b1_prod = cal.b1 * s4_sq_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_vld_r <= 1'b0;
    end else if (en) begin
      s5_vld_r <= s4_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_err_r <= s4_err_r;
      s5_t_r   <= s4_t_r;
      s5_up_r  <= s4_up_r;
      s5_x1_r  <= 32'($signed(b2_prod) >>> 11);
      s5_x2b_r <= 32'($signed(b1_prod) >>> 16);
      s5_x2a_r <= s4_x2a_r;
      s5_x1c_r <= s4_x1c_r;
    end
  end

  // Stage 6: B3 and the X3 term of B4.
  logic [31:0] x3a, b3_pre, x3b;
  logic        s6_vld_r, s6_err_r;
  logic [15:0] s6_t_r;
  logic [23:0] s6_up_r;
  logic [31:0] s6_b3_r, s6_x3_r;

  assign x3a    = s5_x1_r + s5_x2a_r;
  assign b3_pre = (((cal.ac1 << 2) + x3a) << cal.oss) + 32'd2;
  assign x3b    = s5_x1c_r + s5_x2b_r + 32'd2;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s6_vld_r <= 1'b0;
    end else if (en) begin
      s6_vld_r <= s5_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s6_err_r <= s5_err_r;
      s6_t_r   <= s5_t_r;
      s6_up_r  <= s5_up_r;
      s6_b3_r  <= 32'($signed(b3_pre) >>> 2);
      s6_x3_r  <= 32'($signed(x3b) >>> 2);
    end
  end

  // Stage 7: B4 and B7.
  logic [31:0] b4_prod, b7_prod, b7_scale;
  logic        s7_vld_r, s7_err_r;
  logic [15:0] s7_t_r;
  logic [31:0] s7_b4_r, s7_b7_r;

  assign b4_prod  = cal.ac4 * (s6_x3_r + bpc_pkg::B4_OFFSET);
  assign b7_scale = bpc_pkg::B7_SCALE >> cal.oss;
  assign b7_prod  = ({8'd0, s6_up_r} - s6_b3_r) * b7_scale;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s7_vld_r <= 1'b0;
    end else if (en) begin
      s7_vld_r <= s6_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s7_err_r <= s6_err_r;
      s7_t_r   <= s6_t_r;
      s7_b4_r  <= b4_prod >> 15;
      s7_b7_r  <= b7_prod;
    end
  end

  // Pressure quotient: double before dividing when B7 leaves room, else after.
  logic [31:0]    dvd2;
  logic           shift_after, err2;
  logic [SW2-1:0] side2_in, side2_out;
  logic           d2_vld;
  logic [31:0]    d2_quo;

  assign shift_after = s7_b7_r[31];
  assign dvd2        = shift_after ? s7_b7_r : (s7_b7_r << 1);
  assign err2        = s7_err_r || (s7_b4_r == 32'd0);
  assign side2_in    = {s7_t_r, err2, shift_after};

  bpc_div #(.W(W), .SW(SW2)) u_div_p (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (en),
    .in_vld   (s7_vld_r),
    .in_dvd   (dvd2),
    .in_dvs   (s7_b4_r),
    .in_side  (side2_in),
    .out_vld  (d2_vld),
    .out_quo  (d2_quo),
    .out_side (side2_out)
  );

  // Stage 9: pressure and its two correction products.
  logic [15:0] d2_t;
  logic        d2_err, d2_shift;
  logic [31:0] p_raw, p_hi, sq_p, lin_p;
  logic        s9_vld_r, s9_err_r;
  logic [15:0] s9_t_r;
  logic [31:0] s9_p_r, s9_x1_r, s9_x2_r;

  assign {d2_t, d2_err, d2_shift} = side2_out;
  assign p_raw = d2_shift ? (d2_quo << 1) : d2_quo;
  assign p_hi  = 32'($signed(p_raw) >>> 8);
  assign sq_p  = p_hi * p_hi;
  assign lin_p = 32'd0 - bpc_pkg::P_LIN_COEF * p_raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s9_vld_r <= 1'b0;
    end else if (en) begin
      s9_vld_r <= d2_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s9_err_r <= d2_err;
      s9_t_r   <= d2_t;
      s9_p_r   <= p_raw;
      s9_x1_r  <= sq_p;
      s9_x2_r  <= 32'($signed(lin_p) >>> 16);
    end
  end

  // Stage 10: scale the squared term.
  logic [31:0] sq_scaled;
  logic        s10_vld_r, s10_err_r;
  logic [15:0] s10_t_r;
  logic [31:0] s10_p_r, s10_x1_r, s10_x2_r;

  assign sq_scaled = s9_x1_r * bpc_pkg::P_SQ_COEF;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s10_vld_r <= 1'b0;
    end else if (en) begin
      s10_vld_r <= s9_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s10_err_r <= s9_err_r;
      s10_t_r   <= s9_t_r;
      s10_p_r   <= s9_p_r;
      s10_x1_r  <= 32'($signed(sq_scaled) >>> 16);
      s10_x2_r  <= s9_x2_r;
    end
  end

  // Output register: temperature and final pressure, or the error value on both fields.
  logic [31:0]       corr, p_final;
  bpc_pkg::out_res_t res_nxt, res_r;

  assign corr    = s10_x1_r + s10_x2_r + bpc_pkg::P_OFFSET;
  assign p_final = s10_p_r + 32'($signed(corr) >>> 4);

  always_comb begin
    if (s10_err_r) begin
      res_nxt.temperature = bpc_pkg::ERR_VALUE[15:0];
      res_nxt.pressure    = bpc_pkg::ERR_VALUE;
      res_nxt.error_flag  = 1'b1;
    end else begin
      res_nxt.temperature = s10_t_r;
      res_nxt.pressure    = p_final;
      res_nxt.error_flag  = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (en) begin
      out_vld_r <= s10_vld_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = res_r;

  // An error result carries the error value on both fields.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.error_flag |->
      out_data.pressure == bpc_pkg::ERR_VALUE &&
      out_data.temperature == bpc_pkg::ERR_VALUE[15:0])
    else $error("error result without error value");

  // An invalid sample is marked as an error in the first stage.
  assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall && !in_data.sample_valid |=> s1_vld_r && s1_err_r)
    else $error("invalid sample not flagged");

  // Reset leaves no result pending.
  assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

  // A zero pressure divisor always reaches the divider as an error.
  assert property (@(posedge clk) disable iff (!rst_n)
    s7_vld_r && s7_b4_r == 32'd0 |-> err2)
    else $error("zero pressure divisor not flagged");

endmodule

>>> test/barometric_pressure_compensation_tb.sv
// Self-checking testbench for the barometric pressure compensation block.
module barometric_pressure_compensation_tb;

  localparam int LATENCY = 73;
  localparam int CYCLE_LIMIT = 2000000;
  localparam int RANDOM_ITEMS = 1300;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  bpc_pkg::in_req_t in_data = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  bpc_pkg::out_res_t out_data;
  logic cfg_we = 1'b0;
  logic [2:0] cfg_index = '0;
  logic [31:0] cfg_data = '0;

  // Local copy of the calibration registers.
  logic [31:0] cal_regs [0:4];
  logic [1:0] oss_reg;

  bpc_pkg::out_res_t expected_results [$];
  int error_count = 0;
  int cycle_count = 0;

  // One directed row: request plus an optional typed-in result.
  typedef struct {
    bpc_pkg::in_req_t req;
    bit has_result;
    bpc_pkg::out_res_t result;
  } directed_row_t;

  directed_row_t directed_rows [$];

  barometric_pressure_compensation uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #5 clk = ~clk;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] shift_arith(input logic [31:0] v, input int n);
    return $unsigned($signed(v) >>> n);
  endfunction

  // Integer compensation of one raw sample under the current calibration.
  function automatic bpc_pkg::out_res_t compensate(input bpc_pkg::in_req_t req);
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
    logic [31:0] x1, x2, x3, b3, b4, b5, b6, b7, sq, p, up, den, t;
    longint signed quot;
    bpc_pkg::out_res_t res;
    res.temperature = bpc_pkg::ERR_VALUE[15:0];
    res.pressure = bpc_pkg::ERR_VALUE;
    res.error_flag = 1'b1;
    ac1 = sext16(cal_regs[bpc_pkg::REG_AC1_AC2][31:16]);
    ac2 = sext16(cal_regs[bpc_pkg::REG_AC1_AC2][15:0]);
    ac3 = sext16(cal_regs[bpc_pkg::REG_AC3_AC4][31:16]);
    ac4 = {16'd0, cal_regs[bpc_pkg::REG_AC3_AC4][15:0]};
    ac5 = {16'd0, cal_regs[bpc_pkg::REG_AC5_AC6][31:16]};
    ac6 = {16'd0, cal_regs[bpc_pkg::REG_AC5_AC6][15:0]};
    b1 = sext16(cal_regs[bpc_pkg::REG_B1_B2][31:16]);
    b2 = sext16(cal_regs[bpc_pkg::REG_B1_B2][15:0]);
    mc = sext16(cal_regs[bpc_pkg::REG_MC_MD][31:16]);
    md = sext16(cal_regs[bpc_pkg::REG_MC_MD][15:0]);
    if (!req.sample_valid) return res;

    // Temperature part.
    x1 = shift_arith(({16'd0, req.raw_temperature} - ac6) * ac5, 15);
    den = x1 + md;
    if (den == 0) return res;
    quot = longint'($signed(mc * 32'd2048)) / longint'($signed(den));
    x2 = quot[31:0];
    b5 = x1 + x2;
    t = shift_arith(b5 + 32'd8, 4);

    // Pressure part.
    b6 = b5 - bpc_pkg::B6_OFFSET;
    sq = shift_arith(b6 * b6, 12);
    x1 = shift_arith(b2 * sq, 11);
    x2 = shift_arith(ac2 * b6, 11);
    x3 = x1 + x2;
    b3 = shift_arith(((ac1 * 32'd4 + x3) << oss_reg) + 32'd2, 2);
    x1 = shift_arith(ac3 * b6, 13);
    x2 = shift_arith(b1 * sq, 16);
    x3 = shift_arith(x1 + x2 + 32'd2, 2);
    b4 = (ac4 * (x3 + bpc_pkg::B4_OFFSET)) >> 15;
    if (b4 == 0) return res;
    up = {8'd0, req.raw_pressure} >> (8 - oss_reg);
    b7 = (up - b3) * (bpc_pkg::B7_SCALE >> oss_reg);
    if (!b7[31]) p = (b7 << 1) / b4;
    else p = (b7 / b4) << 1;
    x1 = shift_arith(p, 8) * shift_arith(p, 8);
    x1 = shift_arith(x1 * bpc_pkg::P_SQ_COEF, 16);
    x2 = shift_arith(32'd0 - bpc_pkg::P_LIN_COEF * p, 16);
    p = p + shift_arith(x1 + x2 + bpc_pkg::P_OFFSET, 4);
    res.temperature = t[15:0];
    res.pressure = p;
    res.error_flag = 1'b0;
    return res;
  endfunction

  // Cycle limit.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // Result stall: mostly short gaps, some long, some free running stretches.
  always @(posedge clk) begin
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) out_stall <= 1'b0;
    else if (r < 85) out_stall <= 1'($urandom_range(0, 1));
    else if (r < 88) out_stall <= 1'b1;
    else out_stall <= out_stall;
  end

  // Result checker.
  always @(posedge clk) begin
    bpc_pkg::out_res_t exp_res;
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %h", $time, out_data);
        error_count++;
      end else begin
        exp_res = expected_results.pop_front();
        if (out_data.temperature !== exp_res.temperature) begin
          $display("%0t: temperature expected %0d actual %0d", $time,
                   exp_res.temperature, out_data.temperature);
          error_count++;
        end
        if (out_data.pressure !== exp_res.pressure) begin
          $display("%0t: pressure expected %0d actual %0d", $time,
                   exp_res.pressure, out_data.pressure);
          error_count++;
        end
        if (out_data.error_flag !== exp_res.error_flag) begin
          $display("%0t: error flag expected %0b actual %0b", $time,
                   exp_res.error_flag, out_data.error_flag);
          error_count++;
        end
      end
    end
  end

  // One register write; write enable drops again before the task returns, so writes never share a time step.
  task automatic write_reg(input bpc_pkg::reg_idx_t idx, input logic [31:0] value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == bpc_pkg::REG_OSS) oss_reg = value[1:0];
    else cal_regs[idx] = value;
    @(posedge clk);
  endtask

  // Stops sending and waits until the pipeline has drained, then idles for a further margin.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (LATENCY + 5) @(posedge clk);
  endtask

  // Sends one request after a random gap; the predicted result is queued.
  // The request stays valid after acceptance until the next gap or drain.
  task automatic send_request(input bpc_pkg::in_req_t req, input bit typed,
                              input bpc_pkg::out_res_t typed_res);
    int gap;
    bpc_pkg::out_res_t res;
    gap = ($urandom_range(0, 9) < 7) ? 0 :
          (($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3));
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= req;
    res = typed ? typed_res : compensate(req);
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_results.push_back(res);
  endtask

  function automatic bpc_pkg::in_req_t random_request();
    bpc_pkg::in_req_t req;
    req.raw_temperature = $urandom_range(0, 9) < 7 ? 16'($urandom_range(20000, 35000))
                                                   : 16'($urandom);
    req.raw_pressure = $urandom_range(0, 9) < 7 ? 24'($urandom_range(8000000, 11000000))
                                                : 24'($urandom);
    req.sample_valid = $urandom_range(0, 9) != 0;
    return req;
  endfunction

  // Typical datasheet calibration, optionally with random perturbation.
  task automatic load_calibration(input bit perturb);
    logic [31:0] n;
    n = perturb ? $urandom & 32'h003F_003F : '0;
    write_reg(bpc_pkg::REG_AC1_AC2, {16'sd408, -16'sd72} ^ n);
    write_reg(bpc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd32741} ^ n);
    write_reg(bpc_pkg::REG_AC5_AC6, {16'd32757, 16'd23153} ^ n);
    write_reg(bpc_pkg::REG_B1_B2, {16'sd6190, 16'sd4} ^ n);
    write_reg(bpc_pkg::REG_MC_MD, {-16'sd8711, 16'sd2868} ^ n);
  endtask

  initial begin
    bpc_pkg::out_res_t err_res;
    bpc_pkg::in_req_t req;
    int phase;
    for (int i = 0; i < 5; i++) cal_regs[i] = '0;
    oss_reg = 2'd3;
    err_res.temperature = bpc_pkg::ERR_VALUE[15:0];
    err_res.pressure = bpc_pkg::ERR_VALUE;
    err_res.error_flag = 1'b1;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // After reset all coefficients are zero, so MD is zero and the
    // temperature divisor is zero: every request is an error.
    directed_rows.push_back('{'{16'd0, 24'd0, 1'b1}, 1'b1, err_res});
    directed_rows.push_back('{'{16'hFFFF, 24'hFFFFFF, 1'b1}, 1'b1, err_res});
    directed_rows.push_back('{'{16'hFFFF, 24'hFFFFFF, 1'b0}, 1'b1, err_res});
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].has_result, directed_rows[i].result);
    wait_drained();

    // Datasheet calibration: extremes of every field, an invalid sample.
    load_calibration(1'b0);
    write_reg(bpc_pkg::REG_OSS, 2'd0);
    directed_rows.delete();
    directed_rows.push_back('{'{16'd27898, 24'd23843 << 8, 1'b1}, 1'b0, err_res});
    directed_rows.push_back('{'{16'd0, 24'd0, 1'b1}, 1'b0, err_res});
    directed_rows.push_back('{'{16'hFFFF, 24'hFFFFFF, 1'b1}, 1'b0, err_res});
    directed_rows.push_back('{'{16'h8000, 24'h800000, 1'b1}, 1'b0, err_res});
    directed_rows.push_back('{'{16'h7FFF, 24'h7FFFFF, 1'b1}, 1'b0, err_res});
    directed_rows.push_back('{'{16'd27898, 24'd6000000, 1'b0}, 1'b1, err_res});
    foreach (directed_rows[i])
      send_request(directed_rows[i].req, directed_rows[i].has_result, directed_rows[i].result);
    wait_drained();

    // Zero pressure divisor: AC4 of zero makes B4 zero.
    write_reg(bpc_pkg::REG_AC3_AC4, {-16'sd14383, 16'd0});
    send_request('{16'd27898, 24'd6000000, 1'b1}, 1'b1, err_res);
    wait_drained();

    // Temperature divisor zero: with AC5 zero X1 is 0, and MD is set to zero.
    write_reg(bpc_pkg::REG_AC5_AC6, 32'd0);
    write_reg(bpc_pkg::REG_MC_MD, {-16'sd8711, 16'd0});
    send_request('{16'd12345, 24'd6000000, 1'b1}, 1'b1, err_res);
    wait_drained();

    // Extreme coefficients: quotient overflow and temperature wrap.
    write_reg(bpc_pkg::REG_AC1_AC2, 32'h8000_7FFF);
    write_reg(bpc_pkg::REG_AC3_AC4, 32'h7FFF_0001);
    write_reg(bpc_pkg::REG_AC5_AC6, 32'hFFFF_0000);
    write_reg(bpc_pkg::REG_B1_B2, 32'h8000_8000);
    write_reg(bpc_pkg::REG_MC_MD, 32'h7FFF_0001);
    write_reg(bpc_pkg::REG_OSS, 2'd3);
    send_request('{16'hFFFF, 24'hFFFFFF, 1'b1}, 1'b0, err_res);
    send_request('{16'd0, 24'd1, 1'b1}, 1'b0, err_res);
    wait_drained();

    // Random phases across settings.
    for (phase = 0; phase < 8; phase++) begin
      if (phase < 4) load_calibration(1'b1);
      else begin
        write_reg(bpc_pkg::REG_AC1_AC2, $urandom);
        write_reg(bpc_pkg::REG_AC3_AC4, $urandom);
        write_reg(bpc_pkg::REG_AC5_AC6, $urandom);
        write_reg(bpc_pkg::REG_B1_B2, $urandom);
        write_reg(bpc_pkg::REG_MC_MD, $urandom);
      end
      write_reg(bpc_pkg::REG_OSS, 2'(phase));
      for (int i = 0; i < RANDOM_ITEMS / 8; i++) begin
        req = random_request();
        send_request(req, 1'b0, err_res);
        // Hold off once until the pipeline has emptied.
        if (phase == 2 && i == 50) begin
          in_valid <= 1'b0;
          while (expected_results.size() != 0) @(posedge clk);
        end
      end
      wait_drained();
    end

    if (error_count == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule

>>> sim.f
src/bpc_pkg.sv
src/bpc_cfg.sv
src/bpc_div.sv
src/barometric_pressure_compensation.sv
test/barometric_pressure_compensation_tb.sv
